// ===== rtl/core/sdqr_pkg.sv =====
// ----------------------------------------------------------------------------
// sdqr_pkg
// Shared types for the pipelined signed divider.
// ----------------------------------------------------------------------------
package sdqr_pkg;

   // sign and error bits that ride along with each division through the pipe
   typedef struct packed {
      logic quo_neg;
      logic rem_neg;
      logic zero_div;
   } sign_flags_type;

endpackage

// ===== rtl/core/sdqr_req_if.sv =====
// ----------------------------------------------------------------------------
// sdqr_req_if
// Operand channel of the signed divider: dividend and divisor words.
// ----------------------------------------------------------------------------
interface sdqr_req_if #(
   parameter int DATA_WIDTH = 32
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] dividend_in;
   logic signed [DATA_WIDTH-1:0] divisor_in;

   modport source (output valid, output dividend_in, output divisor_in, input ready);
   modport sink   (input valid, input dividend_in, input divisor_in, output ready);
endinterface

// ===== rtl/core/sdqr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sdqr_rsp_if
// Result channel of the signed divider: quotient, remainder, magnitude, error.
// ----------------------------------------------------------------------------
interface sdqr_rsp_if #(
   parameter int DATA_WIDTH = 32
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] quotient_out;
   logic signed [DATA_WIDTH-1:0] remainder_out;
   logic        [DATA_WIDTH-1:0] magnitude_out;
   logic                         zero_divisor;

   modport source (output valid, output quotient_out, output remainder_out,
                   output magnitude_out, output zero_divisor, input ready);
   modport sink   (input valid, input quotient_out, input remainder_out,
                   input magnitude_out, input zero_divisor, output ready);
endinterface

// ===== rtl/core/signed_divider_quotient_remainder_unit.sv =====
// ----------------------------------------------------------------------------
// signed_divider_quotient_remainder_unit
// Fully pipelined signed divider, one division accepted per cycle while rsp_bus is drained.
// ----------------------------------------------------------------------------
// Usage:
//  - req_bus carries a dividend and a divisor word; rsp_bus returns the
//    quotient (truncated toward zero), the remainder (sign of the dividend),
//    the unsigned magnitude of the quotient and a zero-divisor flag.
//  - a zero divisor gives quotient 0, magnitude 0 and the dividend back as
//    remainder; the most negative dividend over -1 wraps the quotient to
//    itself with remainder 0 and magnitude 2^(DATA_WIDTH-1).
//  - from acceptance to rsp_bus.valid a division passes through one operand
//    stage that forms the magnitudes, one restoring step per quotient bit
//    (DATA_WIDTH stages), and one output stage applying signs.
//  - throughput is one word per cycle while rsp_bus is drained.
//  - when the receiver stalls with a result waiting, the whole pipe holds
//    and req_bus.ready drops; nothing is lost or repeated.
//  - reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module signed_divider_quotient_remainder_unit
   import sdqr_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input logic         clock,
   input logic         reset,
   sdqr_req_if.sink    req_bus,
   sdqr_rsp_if.source  rsp_bus
);

   localparam int W = DATA_WIDTH;

   logic advance;

   // operand stage
   logic           op_valid_ff;
   logic [W-1:0]   op_num_ff, op_num_in;
   logic [W-1:0]   op_den_ff, op_den_in;
   sign_flags_type op_flags_ff, op_flags_in;

   logic [W-1:0]   num_raw;
   logic [W-1:0]   den_raw;
   logic           num_neg;
   logic           den_neg;
   logic           den_zero;

   // step chain
   logic           step_valid [W+1];
   logic [W-1:0]   step_rem   [W+1];
   logic [W-1:0]   step_nq    [W+1];
   logic [W-1:0]   step_den   [W+1];
   sign_flags_type step_flags [W+1];

   // output stage
   logic           out_valid_ff;
   logic [W-1:0]   out_quo_ff, out_quo_in;
   logic [W-1:0]   out_rem_ff, out_rem_in;
   logic [W-1:0]   out_mag_ff;
   logic           out_zero_ff;
   logic [W-1:0]   mag_neg;

   assign advance       = ~out_valid_ff | rsp_bus.ready;
   assign req_bus.ready = advance;

   assign num_raw  = $unsigned(req_bus.dividend_in);
   assign den_raw  = $unsigned(req_bus.divisor_in);
   assign num_neg  = num_raw[W-1];
   assign den_neg  = den_raw[W-1];
   assign den_zero = (den_raw == '0);

   assign op_num_in = num_neg ? (~num_raw + 1'b1) : num_raw;
   // a zero divisor is replaced by all ones, which exceeds any dividend
   // magnitude, so the steps yield quotient 0 and the dividend as remainder
   assign op_den_in = den_zero ? '1 : (den_neg ? (~den_raw + 1'b1) : den_raw);
   assign op_flags_in.quo_neg  = (num_neg ^ den_neg) & ~den_zero;
   assign op_flags_in.rem_neg  = num_neg;
   assign op_flags_in.zero_div = den_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff <= 1'b0;
      end else if (advance) begin
         op_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op_num_ff   <= op_num_in;
         op_den_ff   <= op_den_in;
         op_flags_ff <= op_flags_in;
      end
   end

   assign step_valid[0] = op_valid_ff;
   assign step_rem[0]   = '0;
   assign step_nq[0]    = op_num_ff;
   assign step_den[0]   = op_den_ff;
   assign step_flags[0] = op_flags_ff;

   for (genvar i = 0; i < W; i++) begin : g_step
      sdqr_stage #(
         .DATA_WIDTH (W)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .src_valid (step_valid[i]),
         .src_rem   (step_rem[i]),
         .src_nq    (step_nq[i]),
         .src_den   (step_den[i]),
         .src_flags (step_flags[i]),
         .dst_valid (step_valid[i+1]),
         .dst_rem   (step_rem[i+1]),
         .dst_nq    (step_nq[i+1]),
         .dst_den   (step_den[i+1]),
         .dst_flags (step_flags[i+1])
      );
   end

   assign out_quo_in = step_flags[W].quo_neg ? (~step_nq[W] + 1'b1) : step_nq[W];
   assign out_rem_in = step_flags[W].rem_neg ? (~step_rem[W] + 1'b1) : step_rem[W];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= step_valid[W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_quo_ff  <= out_quo_in;
         out_rem_ff  <= out_rem_in;
         out_mag_ff  <= step_nq[W];
         out_zero_ff <= step_flags[W].zero_div;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.quotient_out  = $signed(out_quo_ff);
   assign rsp_bus.remainder_out = $signed(out_rem_ff);
   assign rsp_bus.magnitude_out = out_mag_ff;
   assign rsp_bus.zero_divisor  = out_zero_ff;

   assign mag_neg = ~out_mag_ff + 1'b1;

   // zero divisor results come out with quotient and magnitude cleared
   a_zero_div_result : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_zero_ff |-> out_quo_ff == '0 && out_mag_ff == '0)
      else $error("zero divisor result has nonzero quotient");

   // the signed quotient is the magnitude or its negation
   a_quo_matches_mag : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_quo_ff == out_mag_ff || out_quo_ff == mag_neg)
      else $error("quotient does not match magnitude");

   // after the last step the remainder magnitude is below the divisor
   a_rem_below_den : assert property (@(posedge clock) disable iff (reset)
      step_valid[W] |-> step_rem[W] < step_den[W])
      else $error("remainder not reduced below divisor");

   // a stall freezes the step chain
   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(step_valid[W]) && $stable(step_nq[W]))
      else $error("step chain moved during stall");

endmodule

// ===== rtl/core/sdqr_stage.sv =====
// ----------------------------------------------------------------------------
// sdqr_stage
// One restoring-division step: produces one quotient bit and registers it.
// ----------------------------------------------------------------------------
module sdqr_stage
   import sdqr_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  src_valid,
   input  logic [DATA_WIDTH-1:0] src_rem,
   input  logic [DATA_WIDTH-1:0] src_nq,
   input  logic [DATA_WIDTH-1:0] src_den,
   input  sign_flags_type        src_flags,
   output logic                  dst_valid,
   output logic [DATA_WIDTH-1:0] dst_rem,
   output logic [DATA_WIDTH-1:0] dst_nq,
   output logic [DATA_WIDTH-1:0] dst_den,
   output sign_flags_type        dst_flags
);

   logic                  valid_ff;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] nq_ff, nq_in;
   logic [DATA_WIDTH-1:0] den_ff;
   sign_flags_type        flags_ff;

   logic [DATA_WIDTH:0]   partial;
   logic [DATA_WIDTH:0]   diff;
   logic                  fits;

   // shift the next dividend bit into the partial remainder
   assign partial = {src_rem, src_nq[DATA_WIDTH-1]};
   assign diff    = partial - {1'b0, src_den};
   assign fits    = ~diff[DATA_WIDTH];
   assign rem_in  = fits ? diff[DATA_WIDTH-1:0] : partial[DATA_WIDTH-1:0];
   // dividend bits leave at the top while quotient bits enter at the bottom
   assign nq_in   = {src_nq[DATA_WIDTH-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff   <= rem_in;
         nq_ff    <= nq_in;
         den_ff   <= src_den;
         flags_ff <= src_flags;
      end
   end

   assign dst_valid = valid_ff;
   assign dst_rem   = rem_ff;
   assign dst_nq    = nq_ff;
   assign dst_den   = den_ff;
   assign dst_flags = flags_ff;

endmodule
